// ----- src/algt_pkg.sv -----
// shared types and constants for the graph traversal block
package algt_pkg;

   localparam int MaxVertices = 32;
   localparam int MaxArcs     = 128;
   localparam int VtxW        = $clog2(MaxVertices);
   localparam int ArcW        = $clog2(MaxArcs);
   localparam int VcntW       = $clog2(MaxVertices + 1);
   localparam int AcntW       = $clog2(MaxArcs + 1);

   typedef enum logic [1:0] {
      FUNC_VERTEX = 2'd0,
      FUNC_ARC    = 2'd1,
      FUNC_BFS    = 2'd2,
      FUNC_DFS    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_UNKNOWN  = 3'd2,
      ST_ARC_FULL = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SEARCH,
      S_SEARCH_WAIT,
      S_INS_VTX,
      S_ARC_CHECK,
      S_ARC1_HEAD,
      S_ARC1_WRITE,
      S_ARC2_HEAD,
      S_ARC2_WRITE,
      S_RESULT,
      S_TR_ROOT,
      S_TR_ROOT_WAIT,
      S_TR_ROOT_VISIT,
      S_TR_POP,
      S_TR_POP_WAIT,
      S_TR_ARC,
      S_TR_ARC_WAIT,
      S_TR_TGT_WAIT,
      S_TR_DONE
   } state_type;

endpackage

// ----- src/algt_store.sv -----
// graph memories: vertex labels, list heads and arc entries
module algt_store (
   input  logic                      clock,
   input  logic                      lab_we,
   input  logic [algt_pkg::VtxW-1:0] lab_waddr,
   input  logic [7:0]                lab_wdata,
   input  logic [algt_pkg::VtxW-1:0] lab_raddr,
   output logic [7:0]                lab_rdata,
   input  logic                      head_we,
   input  logic [algt_pkg::VtxW-1:0] head_waddr,
   input  logic [algt_pkg::ArcW:0]   head_wdata,
   input  logic [algt_pkg::VtxW-1:0] head_raddr,
   output logic [algt_pkg::ArcW:0]   head_rdata,
   input  logic                      arc_we,
   input  logic [algt_pkg::ArcW-1:0] arc_waddr,
   input  logic [algt_pkg::VtxW+algt_pkg::ArcW:0] arc_wdata,
   input  logic [algt_pkg::ArcW-1:0] arc_raddr,
   output logic [algt_pkg::VtxW+algt_pkg::ArcW:0] arc_rdata
);

   logic [7:0]                                 lab_mem  [algt_pkg::MaxVertices];
   logic [algt_pkg::ArcW:0]                    head_mem [algt_pkg::MaxVertices];
   logic [algt_pkg::VtxW+algt_pkg::ArcW:0]     arc_mem  [algt_pkg::MaxArcs];

   always_ff @(posedge clock) begin
      if (lab_we) begin
         lab_mem[lab_waddr] <= lab_wdata;
      end
      lab_rdata <= lab_mem[lab_raddr];
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      head_rdata <= head_mem[head_raddr];
   end

   always_ff @(posedge clock) begin
      if (arc_we) begin
         arc_mem[arc_waddr] <= arc_wdata;
      end
      arc_rdata <= arc_mem[arc_raddr];
   end

endmodule

// ----- src/algt_work.sv -----
// traversal work store: queue or stack of vertex and list position
module algt_work (
   input  logic                      clock,
   input  logic                      we,
   input  logic [algt_pkg::VtxW-1:0] waddr,
   input  logic [algt_pkg::VtxW+algt_pkg::ArcW:0] wdata,
   input  logic [algt_pkg::VtxW-1:0] raddr,
   output logic [algt_pkg::VtxW+algt_pkg::ArcW:0] rdata
);

   logic [algt_pkg::VtxW+algt_pkg::ArcW:0] mem [algt_pkg::MaxVertices];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ----- src/adjacency_list_graph_traversal.sv -----
// top level: graph store with vertex and arc insert, breadth and depth first walks
// An insert first searches the stored labels, then writes the vertex or the arc (two
// arcs if undirected; a rejected arc writes nothing), and gives one item with last set.
// A traversal emits one item per vertex (one ST_EMPTY item for an empty graph); its
// pace is set by the registered reads of the memories, and a depth first walk rereads
// the stack top after each arc walked.
// busy falls in the cycle that shows the item with last set; rsp_valid is high for
// one cycle per item and the receiver cannot stall. Configuration (csr_) only while
// busy is low.
module adjacency_list_graph_traversal (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic [7:0] req_vertex_label,
   input  logic [7:0] req_second_label,
   input  logic       csr_we,
   input  logic       csr_undirected,
   output logic       rsp_valid,
   output logic [7:0] rsp_out_label,
   output logic [2:0] rsp_status,
   output logic       rsp_last
);

   localparam int VW = algt_pkg::VtxW;
   localparam int AW = algt_pkg::ArcW;

   algt_pkg::state_type state_ff, state_in;

   logic                     undirected_ff;
   logic [1:0]               func_ff;
   logic [7:0]               a_ff, b_ff;
   logic [algt_pkg::VcntW-1:0] vcnt_ff;
   logic [algt_pkg::AcntW-1:0] acnt_ff;
   logic [algt_pkg::VcntW-1:0] idx_ff;
   logic                     a_found_ff, b_found_ff;
   logic [VW-1:0]            s_ff, d_ff;
   logic [algt_pkg::MaxVertices-1:0] visited_ff;
   logic [algt_pkg::VcntW-1:0] qh_ff, qt_ff;
   logic [VW-1:0]            u_ff, t_ff;
   logic                     pos_ok_ff;
   logic [AW-1:0]            pos_ff;
   logic                     rv_ff, rl_ff;
   logic                     rv_in;
   logic [7:0]               rlab_ff;
   logic [2:0]               rst_ff;
   logic                     pend_ff;
   logic [7:0]               plab_ff;

   // memory ports
   logic                     lab_we, head_we, arc_we, wk_we;
   logic [VW-1:0]            lab_waddr, lab_raddr, head_waddr, head_raddr, wk_waddr, wk_raddr;
   logic [7:0]               lab_wdata, lab_rdata;
   logic [AW:0]              head_wdata, head_rdata;
   logic [AW-1:0]            arc_waddr, arc_raddr;
   logic [VW+AW:0]           arc_wdata, arc_rdata, wk_wdata, wk_rdata;

   algt_store u_store (
      .clock, .lab_we, .lab_waddr, .lab_wdata, .lab_raddr, .lab_rdata,
      .head_we, .head_waddr, .head_wdata, .head_raddr, .head_rdata,
      .arc_we, .arc_waddr, .arc_wdata, .arc_raddr, .arc_rdata
   );

   algt_work u_work (
      .clock, .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
      .raddr(wk_raddr), .rdata(wk_rdata)
   );

   logic is_dfs;
   logic [VW-1:0] idx_v, arc_t;
   logic [AW-1:0] arc_nx;
   logic          arc_ok;
   logic          t_new;

   assign is_dfs = (func_ff == algt_pkg::FUNC_DFS);
   assign idx_v  = idx_ff[VW-1:0];
   assign arc_t  = arc_rdata[VW+AW:AW+1];
   assign arc_ok = arc_rdata[AW];
   assign arc_nx = arc_rdata[AW-1:0];
   assign t_new  = ({1'b0, t_ff} < vcnt_ff) && !visited_ff[t_ff];
   assign busy   = (state_ff != algt_pkg::S_IDLE);

   assign rv_in = (state_ff == algt_pkg::S_RESULT) || (state_ff == algt_pkg::S_TR_DONE) ||
                  (pend_ff && state_ff == algt_pkg::S_TR_ROOT_VISIT) ||
                  (pend_ff && state_ff == algt_pkg::S_TR_TGT_WAIT && t_new &&
                   qt_ff < algt_pkg::MaxVertices);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         algt_pkg::S_IDLE: begin
            if (start) begin
               state_in = algt_pkg::S_SEARCH;
            end
         end
         algt_pkg::S_SEARCH: begin
            if (func_ff == algt_pkg::FUNC_BFS || func_ff == algt_pkg::FUNC_DFS) begin
               state_in = (vcnt_ff == '0) ? algt_pkg::S_RESULT : algt_pkg::S_TR_ROOT;
            end else if (idx_ff == vcnt_ff) begin
               state_in = (func_ff == algt_pkg::FUNC_VERTEX) ? algt_pkg::S_INS_VTX
                                                            : algt_pkg::S_ARC_CHECK;
            end else begin
               state_in = algt_pkg::S_SEARCH_WAIT;
            end
         end
         algt_pkg::S_SEARCH_WAIT: state_in = algt_pkg::S_SEARCH;
         algt_pkg::S_INS_VTX:     state_in = algt_pkg::S_RESULT;
         algt_pkg::S_ARC_CHECK: begin
            if (!a_found_ff || !b_found_ff ||
                (acnt_ff + (undirected_ff ? 2 : 1)) > algt_pkg::MaxArcs) begin
               state_in = algt_pkg::S_RESULT;
            end else begin
               state_in = algt_pkg::S_ARC1_HEAD;
            end
         end
         algt_pkg::S_ARC1_HEAD:  state_in = algt_pkg::S_ARC1_WRITE;
         algt_pkg::S_ARC1_WRITE:
            state_in = undirected_ff ? algt_pkg::S_ARC2_HEAD : algt_pkg::S_RESULT;
         algt_pkg::S_ARC2_HEAD:  state_in = algt_pkg::S_ARC2_WRITE;
         algt_pkg::S_ARC2_WRITE: state_in = algt_pkg::S_RESULT;
         algt_pkg::S_RESULT:     state_in = algt_pkg::S_IDLE;
         algt_pkg::S_TR_ROOT: begin
            if (idx_ff == vcnt_ff) begin
               state_in = algt_pkg::S_TR_DONE;
            end else if (visited_ff[idx_v]) begin
               state_in = algt_pkg::S_TR_ROOT;
            end else begin
               state_in = algt_pkg::S_TR_ROOT_WAIT;
            end
         end
         algt_pkg::S_TR_ROOT_WAIT:  state_in = algt_pkg::S_TR_ROOT_VISIT;
         algt_pkg::S_TR_ROOT_VISIT: state_in = algt_pkg::S_TR_POP;
         algt_pkg::S_TR_POP: begin
            if (is_dfs ? (qt_ff == '0) : (qh_ff == qt_ff)) begin
               state_in = algt_pkg::S_TR_ROOT;
            end else begin
               state_in = algt_pkg::S_TR_POP_WAIT;
            end
         end
         algt_pkg::S_TR_POP_WAIT: state_in = algt_pkg::S_TR_ARC;
         algt_pkg::S_TR_ARC: begin
            if (!pos_ok_ff) begin
               state_in = algt_pkg::S_TR_POP;
            end else begin
               state_in = algt_pkg::S_TR_ARC_WAIT;
            end
         end
         algt_pkg::S_TR_ARC_WAIT: state_in = algt_pkg::S_TR_TGT_WAIT;
         algt_pkg::S_TR_TGT_WAIT: begin
            state_in = is_dfs ? algt_pkg::S_TR_POP : algt_pkg::S_TR_ARC;
         end
         algt_pkg::S_TR_DONE: state_in = algt_pkg::S_IDLE;
         default: state_in = algt_pkg::S_IDLE;
      endcase
   end

   // memory addressing and writes
   always_comb begin
      lab_we = 1'b0; lab_waddr = vcnt_ff[VW-1:0]; lab_wdata = a_ff;
      lab_raddr = idx_v;
      head_we = 1'b0; head_waddr = s_ff; head_wdata = {1'b1, acnt_ff[AW-1:0]};
      head_raddr = idx_v;
      arc_we = 1'b0; arc_waddr = acnt_ff[AW-1:0];
      arc_wdata = {d_ff, head_rdata};
      arc_raddr = pos_ff;
      wk_we = 1'b0; wk_waddr = qt_ff[VW-1:0]; wk_wdata = {u_ff, pos_ok_ff, pos_ff};
      wk_raddr = is_dfs ? (qt_ff[VW-1:0] - 1'b1) : qh_ff[VW-1:0];
      unique case (state_ff)
         algt_pkg::S_INS_VTX: begin
            if (!a_found_ff && vcnt_ff < algt_pkg::MaxVertices) begin
               lab_we = 1'b1;
               head_we = 1'b1; head_waddr = vcnt_ff[VW-1:0]; head_wdata = '0;
            end
         end
         algt_pkg::S_ARC_CHECK:  head_raddr = s_ff;
         algt_pkg::S_ARC1_HEAD:  head_raddr = s_ff;
         algt_pkg::S_ARC1_WRITE: begin
            arc_we = 1'b1; arc_wdata = {d_ff, head_rdata};
            head_we = 1'b1; head_waddr = s_ff;
            head_raddr = d_ff;
         end
         algt_pkg::S_ARC2_HEAD: head_raddr = d_ff;
         algt_pkg::S_ARC2_WRITE: begin
            arc_we = 1'b1; arc_wdata = {s_ff, head_rdata};
            head_we = 1'b1; head_waddr = d_ff;
         end
         algt_pkg::S_TR_ROOT_WAIT: ;
         algt_pkg::S_TR_ROOT_VISIT: begin
            wk_we = 1'b1; wk_waddr = '0;
            wk_wdata = {idx_v, head_rdata};
         end
         algt_pkg::S_TR_ARC_WAIT: begin
            lab_raddr = arc_t; head_raddr = arc_t;
            if (is_dfs) begin
               wk_we = 1'b1; wk_waddr = qt_ff[VW-1:0] - 1'b1;
               wk_wdata = {u_ff, arc_ok, arc_nx};
            end
         end
         algt_pkg::S_TR_TGT_WAIT: begin
            if (t_new && qt_ff < algt_pkg::MaxVertices) begin
               wk_we = 1'b1; wk_waddr = qt_ff[VW-1:0];
               wk_wdata = {t_ff, head_rdata};
            end
         end
         default: ;
      endcase
   end

   // control and data registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= algt_pkg::S_IDLE;
         undirected_ff <= 1'b0;
         vcnt_ff <= '0;
         acnt_ff <= '0;
         rv_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         if (csr_we) begin
            undirected_ff <= csr_undirected;
         end
         unique case (state_ff)
            algt_pkg::S_IDLE: begin
               if (start) begin
                  func_ff <= req_func;
                  a_ff <= req_vertex_label;
                  b_ff <= req_second_label;
                  idx_ff <= '0;
                  a_found_ff <= 1'b0;
                  b_found_ff <= 1'b0;
                  visited_ff <= '0;
                  qh_ff <= '0;
                  qt_ff <= '0;
                  pend_ff <= 1'b0;
               end
            end
            algt_pkg::S_SEARCH: ;
            algt_pkg::S_SEARCH_WAIT: begin
               if (lab_rdata == a_ff && !a_found_ff) begin
                  a_found_ff <= 1'b1; s_ff <= idx_v;
               end
               if (lab_rdata == b_ff && !b_found_ff) begin
                  b_found_ff <= 1'b1; d_ff <= idx_v;
               end
               idx_ff <= idx_ff + 1'b1;
            end
            algt_pkg::S_INS_VTX: begin
               rlab_ff <= '0;
               if (!a_found_ff && vcnt_ff < algt_pkg::MaxVertices) begin
                  vcnt_ff <= vcnt_ff + 1'b1;
                  rst_ff <= algt_pkg::ST_OK;
               end else begin
                  rst_ff <= algt_pkg::ST_DUP;
               end
            end
            algt_pkg::S_ARC_CHECK: begin
               rlab_ff <= '0;
               if (!a_found_ff || !b_found_ff) begin
                  rst_ff <= algt_pkg::ST_UNKNOWN;
               end else if ((acnt_ff + (undirected_ff ? 2 : 1)) > algt_pkg::MaxArcs) begin
                  rst_ff <= algt_pkg::ST_ARC_FULL;
               end else begin
                  rst_ff <= algt_pkg::ST_OK;
               end
            end
            algt_pkg::S_ARC1_WRITE, algt_pkg::S_ARC2_WRITE: acnt_ff <= acnt_ff + 1'b1;
            algt_pkg::S_RESULT: begin
               rl_ff <= 1'b1;
               if (func_ff == algt_pkg::FUNC_BFS || func_ff == algt_pkg::FUNC_DFS) begin
                  rlab_ff <= '0; rst_ff <= algt_pkg::ST_EMPTY;
               end
            end
            algt_pkg::S_TR_ROOT: begin
               if (idx_ff != vcnt_ff && visited_ff[idx_v]) begin
                  idx_ff <= idx_ff + 1'b1;
               end
               qh_ff <= '0; qt_ff <= '0;
            end
            algt_pkg::S_TR_ROOT_VISIT: begin
               if (pend_ff) begin
                  rlab_ff <= plab_ff; rst_ff <= algt_pkg::ST_OK;
                  rl_ff <= 1'b0;
               end
               pend_ff <= 1'b1; plab_ff <= lab_rdata;
               visited_ff[idx_v] <= 1'b1;
               qt_ff <= algt_pkg::VcntW'(1);
               idx_ff <= idx_ff + 1'b1;
            end
            algt_pkg::S_TR_POP: begin
               if (is_dfs) begin
                  if (qt_ff != '0) ; // top read issued
               end
            end
            algt_pkg::S_TR_POP_WAIT: begin
               u_ff <= wk_rdata[VW+AW:AW+1];
               pos_ok_ff <= wk_rdata[AW];
               pos_ff <= wk_rdata[AW-1:0];
               if (!is_dfs) begin
                  qh_ff <= qh_ff + 1'b1;
               end else if (!wk_rdata[AW]) begin
                  qt_ff <= qt_ff - 1'b1;
               end
            end
            algt_pkg::S_TR_ARC: ;
            algt_pkg::S_TR_ARC_WAIT: begin
               t_ff <= arc_t;
               pos_ok_ff <= arc_ok;
               pos_ff <= arc_nx;
            end
            algt_pkg::S_TR_TGT_WAIT: begin
               if (t_new && qt_ff < algt_pkg::MaxVertices) begin
                  if (pend_ff) begin
                     rlab_ff <= plab_ff; rst_ff <= algt_pkg::ST_OK;
                     rl_ff <= 1'b0;
                  end
                  pend_ff <= 1'b1; plab_ff <= lab_rdata;
                  visited_ff[t_ff] <= 1'b1;
                  qt_ff <= qt_ff + 1'b1;
               end
            end
            algt_pkg::S_TR_DONE: begin
               rlab_ff <= plab_ff; rst_ff <= algt_pkg::ST_OK;
               rl_ff <= 1'b1; pend_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid     = rv_ff;
   assign rsp_out_label = rlab_ff;
   assign rsp_status    = rst_ff;
   assign rsp_last      = rl_ff;

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy) else $error("busy after last item");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
   a_counts: assert property (@(posedge clock) disable iff (reset)
      vcnt_ff <= algt_pkg::MaxVertices && acnt_ff <= algt_pkg::MaxArcs)
      else $error("count overflow");

endmodule

// ----- tb/tb_adjacency_list_graph_traversal.sv -----
// testbench for the adjacency list graph store with breadth and depth first walks
module tb_adjacency_list_graph_traversal;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      algt_pkg::func_type func;
      logic [7:0]         label_a;
      logic [7:0]         label_b;
   } cmd_type;

   typedef struct packed {
      logic [7:0]           label;
      algt_pkg::status_type status;
      logic                 last;
   } visit_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_func;
   logic [7:0] req_vertex_label;
   logic [7:0] req_second_label;
   logic       csr_we;
   logic       csr_undirected;
   logic       rsp_valid;
   logic [7:0] rsp_out_label;
   logic [2:0] rsp_status;
   logic       rsp_last;

   adjacency_list_graph_traversal dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_vertex_label(req_vertex_label),
      .req_second_label(req_second_label), .csr_we(csr_we),
      .csr_undirected(csr_undirected), .rsp_valid(rsp_valid),
      .rsp_out_label(rsp_out_label), .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   // graph mirror
   logic [7:0] g_labels [algt_pkg::MaxVertices];
   int         g_vcount;
   int         g_head [algt_pkg::MaxVertices];
   int         g_target [algt_pkg::MaxArcs];
   int         g_next [algt_pkg::MaxArcs];
   int         g_acount;
   logic       g_undirected;

   cmd_type   pending_cmds[$];
   visit_type expected_visits[$];
   int        mismatches;
   int        accepted;
   bit        quiet;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int find_vertex(logic [7:0] lab);
      for (int i = 0; i < g_vcount; i++)
         if (g_labels[i] == lab) return i;
      return -1;
   endfunction

   function automatic void push_visit(logic [7:0] lab, algt_pkg::status_type st, logic lst);
      visit_type v;
      v.label = lab;
      v.status = st;
      v.last = lst;
      expected_visits.push_back(v);
   endfunction

   function automatic void link_arc(int from, int to);
      g_target[g_acount] = to;
      g_next[g_acount] = g_head[from];
      g_head[from] = g_acount;
      g_acount++;
   endfunction

   // -1 marks the end of a list
   function automatic void predict_walk(cmd_type c);
      bit seen [algt_pkg::MaxVertices];
      int work [algt_pkg::MaxVertices];
      int pos [algt_pkg::MaxVertices];
      int qh, qt, sp, u, p, t;
      for (int i = 0; i < algt_pkg::MaxVertices; i++) seen[i] = 0;
      for (int i = 0; i < g_vcount; i++) begin
         if (seen[i]) continue;
         push_visit(g_labels[i], algt_pkg::ST_OK, 1'b0);
         seen[i] = 1;
         if (c.func == algt_pkg::FUNC_BFS) begin
            qh = 0;
            qt = 1;
            work[0] = i;
            while (qh < qt) begin
               u = work[qh];
               qh++;
               p = g_head[u];
               while (p >= 0) begin
                  t = g_target[p];
                  if (!seen[t] && qt < algt_pkg::MaxVertices) begin
                     push_visit(g_labels[t], algt_pkg::ST_OK, 1'b0);
                     seen[t] = 1;
                     work[qt] = t;
                     qt++;
                  end
                  p = g_next[p];
               end
            end
         end else begin
            work[0] = i;
            pos[0] = g_head[i];
            sp = 1;
            while (sp > 0) begin
               if (pos[sp-1] < 0) begin
                  sp--;
                  continue;
               end
               p = pos[sp-1];
               t = g_target[p];
               pos[sp-1] = g_next[p];
               if (!seen[t] && sp < algt_pkg::MaxVertices) begin
                  push_visit(g_labels[t], algt_pkg::ST_OK, 1'b0);
                  seen[t] = 1;
                  work[sp] = t;
                  pos[sp] = g_head[t];
                  sp++;
               end
            end
         end
      end
      expected_visits[expected_visits.size()-1].last = 1'b1;
   endfunction

   function automatic void predict_item(cmd_type c);
      int s, d, need;
      case (c.func)
         algt_pkg::FUNC_VERTEX: begin
            if (find_vertex(c.label_a) >= 0 || g_vcount >= algt_pkg::MaxVertices) begin
               push_visit(8'd0, algt_pkg::ST_DUP, 1'b1);
            end else begin
               g_labels[g_vcount] = c.label_a;
               g_head[g_vcount] = -1;
               g_vcount++;
               push_visit(8'd0, algt_pkg::ST_OK, 1'b1);
            end
         end
         algt_pkg::FUNC_ARC: begin
            s = find_vertex(c.label_a);
            d = find_vertex(c.label_b);
            need = g_undirected ? 2 : 1;
            if (s < 0 || d < 0) begin
               push_visit(8'd0, algt_pkg::ST_UNKNOWN, 1'b1);
            end else if (g_acount + need > algt_pkg::MaxArcs) begin
               push_visit(8'd0, algt_pkg::ST_ARC_FULL, 1'b1);
            end else begin
               link_arc(s, d);
               if (g_undirected) link_arc(d, s);
               push_visit(8'd0, algt_pkg::ST_OK, 1'b1);
            end
         end
         default: begin
            if (g_vcount == 0) push_visit(8'd0, algt_pkg::ST_EMPTY, 1'b1);
            else predict_walk(c);
         end
      endcase
   endfunction

   // driver
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else if (!(start && !busy) && start) begin
         // hold the item until taken
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_cmds.size() > 0) begin
         cmd_type c;
         c = pending_cmds.pop_front();
         predict_item(c);
         accepted++;
         start <= 1'b1;
         req_func <= c.func;
         req_vertex_label <= c.label_a;
         req_second_label <= c.label_b;
         if (!quiet && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 17);
      end else begin
         start <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_visits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: label %0d status %0d last %0d",
                        rsp_out_label, rsp_status, rsp_last);
         end else begin
            visit_type e;
            e = expected_visits.pop_front();
            if (rsp_out_label !== e.label || rsp_status !== e.status
                || rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected label %0d status %0d last %0d, got %0d %0d %0d",
                           e.label, e.status, e.last, rsp_out_label, rsp_status,
                           rsp_last);
            end
         end
      end
   end

   task automatic add_cmd(algt_pkg::func_type f, logic [7:0] a, logic [7:0] b);
      cmd_type c;
      c.func = f;
      c.label_a = a;
      c.label_b = b;
      pending_cmds.push_back(c);
   endtask

   task automatic drain();
      while (pending_cmds.size() > 0 || start || busy || expected_visits.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_mode(logic u);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_undirected <= u;
      g_undirected = u;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly labels from a small pool so arcs usually hit known vertices
   function automatic logic [7:0] pick_label();
      if ($urandom_range(0, 9) == 0) return 8'($urandom);
      return 8'($urandom_range(0, 39));
   endfunction

   task automatic random_phase(int count, int arc_bias);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30) add_cmd(algt_pkg::FUNC_VERTEX, pick_label(), 8'($urandom));
         else if (r < 30 + arc_bias) add_cmd(algt_pkg::FUNC_ARC, pick_label(), pick_label());
         else if (r % 2 == 0) add_cmd(algt_pkg::FUNC_BFS, 8'($urandom), 8'($urandom));
         else add_cmd(algt_pkg::FUNC_DFS, 8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      clock = 1'b0;
      mismatches = 0;
      accepted = 0;
      quiet = 0;
      g_vcount = 0;
      g_acount = 0;
      g_undirected = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_func = 2'd0;
      req_vertex_label = 8'd0;
      req_second_label = 8'd0;
      csr_we = 1'b0;
      csr_undirected = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part: empty graph, duplicates, unknowns, self and duplicate arcs
      add_cmd(algt_pkg::FUNC_BFS, 8'hFF, 8'h00);
      add_cmd(algt_pkg::FUNC_DFS, 8'h00, 8'hFF);
      add_cmd(algt_pkg::FUNC_VERTEX, 8'h00, 8'h00);
      add_cmd(algt_pkg::FUNC_VERTEX, 8'hFF, 8'hFF);
      add_cmd(algt_pkg::FUNC_VERTEX, 8'hFF, 8'h00);
      add_cmd(algt_pkg::FUNC_VERTEX, 8'h55, 8'h00);
      add_cmd(algt_pkg::FUNC_ARC, 8'h00, 8'hFF);
      add_cmd(algt_pkg::FUNC_ARC, 8'h00, 8'hFF);
      add_cmd(algt_pkg::FUNC_ARC, 8'hFF, 8'h55);
      add_cmd(algt_pkg::FUNC_ARC, 8'h55, 8'h55);
      add_cmd(algt_pkg::FUNC_ARC, 8'hAA, 8'h00);
      add_cmd(algt_pkg::FUNC_ARC, 8'h00, 8'hAA);
      add_cmd(algt_pkg::FUNC_BFS, 8'h00, 8'h00);
      add_cmd(algt_pkg::FUNC_DFS, 8'hFF, 8'hFF);
      drain();
      write_mode(1'b1);
      add_cmd(algt_pkg::FUNC_VERTEX, 8'hAA, 8'h00);
      add_cmd(algt_pkg::FUNC_ARC, 8'hAA, 8'hAA);
      add_cmd(algt_pkg::FUNC_ARC, 8'h55, 8'hAA);
      add_cmd(algt_pkg::FUNC_BFS, 8'h00, 8'h00);
      add_cmd(algt_pkg::FUNC_DFS, 8'h00, 8'h00);
      drain();

      random_phase(70, 45);
      drain();
      write_mode(1'b0);
      random_phase(70, 50);
      drain();
      // fill the tables to reach full vertex (reported as ST_DUP) and full arc status
      write_mode(1'b1);
      random_phase(60, 60);
      quiet = 1;
      for (int i = 0; i < 40; i++) add_cmd(algt_pkg::FUNC_VERTEX, 8'(i), 8'h00);
      for (int i = 0; i < 70; i++)
         add_cmd(algt_pkg::FUNC_ARC, 8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)));
      add_cmd(algt_pkg::FUNC_BFS, 8'h00, 8'h00);
      add_cmd(algt_pkg::FUNC_DFS, 8'h00, 8'h00);
      drain();

      if (mismatches == 0 && expected_visits.size() == 0)
         $display("** adjacency_list_graph_traversal: PASSED **");
      else
         $display("** adjacency_list_graph_traversal: FAILED **");
      $finish;
   end

   initial begin
      #20ms;
      $display("** adjacency_list_graph_traversal: FAILED **");
      $finish;
   end

endmodule
